// ----- sv/brle_pkg.sv -----
// Shared types and constants for the BMP RLE8 pixel decoder.
// No dependencies; brle_if and the top level refer to it by scoped names.
package brle_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PALETTE_DEPTH = 256;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 16;
    localparam int RUN_W   = 21;
    localparam int CFG_W   = 11;
    localparam int POS_W   = 11;
    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);

    // Depth of the result queue that decouples the parser from the receiver.
    localparam int RESQ_DEPTH = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_PAL_WRITE = 2'd0,
        CMD_IMAGE     = 2'd1,
        CMD_RESTART   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_DX      = 3'd2,
        PH_DY      = 3'd3,
        PH_LITERAL = 3'd4,
        PH_PAD     = 3'd5
    } t_phase;

    localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

    localparam logic [BYTE_W-1:0] ESC_EOL   = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_EOB   = 8'd1;
    localparam logic [BYTE_W-1:0] ESC_DELTA = 8'd2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd800;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [RUN_W-1:0] RUN_MAX = '1;

    // One queued entry: an input item's results, one or two runs of one color.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [RUN_W-1:0]   cnt0;
        logic [RUN_W-1:0]   cnt1;
        logic               two;
    } t_entry;

endpackage

// ----- sv/brle_if.sv -----
// Valid/ready channel interfaces of the BMP RLE8 pixel decoder.
// Depends on brle_pkg for the field widths.
interface brle_req_if;
    logic                        valid;
    logic                        ready;
    logic [brle_pkg::CMD_W-1:0]  cmd;
    logic [brle_pkg::BYTE_W-1:0] data_byte;
    logic [brle_pkg::BYTE_W-1:0] pal_red;
    logic [brle_pkg::BYTE_W-1:0] pal_green;
    logic [brle_pkg::BYTE_W-1:0] pal_blue;

    modport source(output valid, cmd, data_byte, pal_red, pal_green, pal_blue, input ready);
    modport sink(input valid, cmd, data_byte, pal_red, pal_green, pal_blue, output ready);
endinterface

interface brle_res_if;
    logic                         valid;
    logic                         ready;
    logic [brle_pkg::COLOR_W-1:0] pixel_color;
    logic [brle_pkg::RUN_W-1:0]   repeat_count;
    logic                         run_last;
    logic                         image_done;

    modport source(output valid, pixel_color, repeat_count, run_last, image_done, input ready);
    modport sink(input valid, pixel_color, repeat_count, run_last, image_done, output ready);
endinterface

// ----- sv/brle_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module brle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/bmp_rle8_pixel_decoder.sv -----
// BMP RLE8 pixel decoder: top level with parser, palette RAM and result queue.
// Depends on brle_pkg, brle_req_if/brle_res_if and brle_ram.
//
// Usage: requests arrive on i_req. A palette write (cmd 0) stores the RGB565
// form of pal_red/green/blue at index data_byte. An image byte (cmd 1) feeds
// the RLE8 parser. A restart (cmd 2) clears the parser and the positions but
// keeps the palette. Each request causes zero, one or two runs on o_res, a
// color and a repeat count; run_last marks the last run of a request and
// image_done marks the final fill of the end-of-bitmap escape.
// Throughput: one request per cycle while the queue has room. An accepted
// request has its palette read and the s1 stage loaded; its counts are then
// multiplied out and its runs written into the queue, which drives o_res.
// The end-of-bitmap escape delivers two runs, one after the other, from one queue entry.
// The palette lives in a 256 x 16 RAM with one write and one read port; its
// single read port sets the rate at one request per cycle.
// Runs wait in a four-entry queue; when the receiver stalls the queue fills
// and i_req.ready drops, so nothing is lost. Reset (synchronous, active low)
// clears the parser, positions, the queue and sets width 800 and height 480;
// the palette is undefined until written. Configuration is written through
// i_cfg_we/i_cfg_idx/i_cfg_wdata while the block is idle.
module bmp_rle8_pixel_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [0:0]                       i_cfg_idx,
    input  logic [brle_pkg::CFG_W-1:0]       i_cfg_wdata,
    brle_req_if.sink                         i_req,
    brle_res_if.source                       o_res
);

    localparam int QAW = $clog2(brle_pkg::RESQ_DEPTH);
    localparam int QCW = $clog2(brle_pkg::RESQ_DEPTH + 1);
    localparam int PW  = 2 * brle_pkg::CFG_W;

    // Configuration.
    logic [brle_pkg::CFG_W-1:0] r_image_width, r_image_height;
    logic [brle_pkg::CFG_W-1:0] eff_w, eff_h;

    // Parser state.
    brle_pkg::t_phase            r_phase, n_phase;
    logic [brle_pkg::BYTE_W-1:0] r_first_byte, n_first_byte;
    logic [brle_pkg::BYTE_W-1:0] r_lit_rem, n_lit_rem;
    logic                        r_pad_pending, n_pad_pending;
    logic [brle_pkg::BYTE_W-1:0] r_delta_dx, n_delta_dx;
    logic [brle_pkg::POS_W-1:0]  r_col, n_col;
    logic [brle_pkg::POS_W-1:0]  r_line, n_line;
    logic                        r_finished, n_finished;

    // Stage between the palette read and the queue.
    logic                        r_s1_valid, n_s1_valid;
    logic                        r_s1_two, n_s1_two;
    logic                        r_s1_mul_to0, n_s1_mul_to0;
    logic [brle_pkg::CFG_W-1:0]  r_s1_base, n_s1_base;
    logic [brle_pkg::CFG_W-1:0]  r_s1_mul_a, n_s1_mul_a;

    // Result queue.
    brle_pkg::t_entry            r_q [brle_pkg::RESQ_DEPTH];
    logic [QAW-1:0]              r_wptr, r_rptr;
    logic [QCW-1:0]              r_qcnt, n_qcnt;
    logic                        r_sub;

    // Palette RAM ports.
    logic                         pal_we;
    logic [brle_pkg::PAL_AW-1:0]  pal_raddr;
    logic [brle_pkg::COLOR_W-1:0] pal_wdata, pal_rdata;

    logic                         acc;
    logic                         push, pop;
    logic [brle_pkg::POS_W:0]     col_sum_a, col_sum_b, line_sum;
    logic [brle_pkg::CFG_W:0]     line_p1;
    logic [brle_pkg::CFG_W-1:0]   fill_eol, lines_left;
    logic [PW-1:0]                prod;
    logic [PW:0]                  sum0;
    logic [brle_pkg::RUN_W-1:0]   cnt0, cnt1;
    brle_pkg::t_entry             head;

    assign eff_w = (int'(r_image_width) > brle_pkg::MAX_WIDTH)
                 ? brle_pkg::CFG_W'(brle_pkg::MAX_WIDTH) : r_image_width;
    assign eff_h = (int'(r_image_height) > brle_pkg::MAX_HEIGHT)
                 ? brle_pkg::CFG_W'(brle_pkg::MAX_HEIGHT) : r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= brle_pkg::WIDTH_RESET;
            r_image_height <= brle_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == brle_pkg::CFG_IDX_WIDTH) begin
                r_image_width <= i_cfg_wdata;
            end else if (i_cfg_idx == brle_pkg::CFG_IDX_HEIGHT) begin
                r_image_height <= i_cfg_wdata;
            end
        end
    end

    // The queue is never overrun: the stage in flight is counted as occupied.
    assign i_req.ready = (r_qcnt + QCW'(r_s1_valid)) < QCW'(brle_pkg::RESQ_DEPTH);
    assign acc = i_req.valid && i_req.ready;

    assign pal_wdata = {i_req.pal_red[7:3], i_req.pal_green[7:2], i_req.pal_blue[7:3]};

    // Saturating position sums and line-end fill amounts.
    assign col_sum_a  = {1'b0, r_col} + (brle_pkg::POS_W+1)'(r_first_byte);
    assign col_sum_b  = {1'b0, r_col} + (brle_pkg::POS_W+1)'(r_delta_dx);
    assign line_sum   = {1'b0, r_line} + (brle_pkg::POS_W+1)'(i_req.data_byte);
    assign line_p1    = {1'b0, r_line} + 1'b1;
    assign fill_eol   = (eff_w > r_col) ? eff_w - r_col : '0;
    assign lines_left = ({1'b0, eff_h} > line_p1) ? brle_pkg::CFG_W'({1'b0, eff_h} - line_p1)
                                                  : '0;

    always_comb begin
        n_phase       = r_phase;
        n_first_byte  = r_first_byte;
        n_lit_rem     = r_lit_rem;
        n_pad_pending = r_pad_pending;
        n_delta_dx    = r_delta_dx;
        n_col         = r_col;
        n_line        = r_line;
        n_finished    = r_finished;
        n_s1_valid    = 1'b0;
        n_s1_two      = 1'b0;
        n_s1_mul_to0  = 1'b0;
        n_s1_base     = '0;
        n_s1_mul_a    = '0;
        pal_we        = 1'b0;
        pal_raddr     = '0;

        if (acc) begin
            case (brle_pkg::t_cmd'(i_req.cmd))
                brle_pkg::CMD_PAL_WRITE: begin
                    pal_we = 1'b1;
                end
                brle_pkg::CMD_RESTART: begin
                    n_phase       = brle_pkg::PH_COUNT;
                    n_first_byte  = '0;
                    n_lit_rem     = '0;
                    n_pad_pending = 1'b0;
                    n_delta_dx    = '0;
                    n_col         = '0;
                    n_line        = '0;
                    n_finished    = 1'b0;
                end
                brle_pkg::CMD_IMAGE: begin
                    if (!r_finished) begin
                        unique case (r_phase)
                            brle_pkg::PH_COUNT: begin
                                n_first_byte = i_req.data_byte;
                                n_phase      = brle_pkg::PH_SECOND;
                            end
                            brle_pkg::PH_SECOND: begin
                                n_phase = brle_pkg::PH_COUNT;
                                if (r_first_byte != '0) begin
                                    n_s1_valid = 1'b1;
                                    n_s1_base  = brle_pkg::CFG_W'(r_first_byte);
                                    pal_raddr  = i_req.data_byte;
                                    n_col      = col_sum_a[brle_pkg::POS_W]
                                               ? brle_pkg::POS_MAX
                                               : col_sum_a[brle_pkg::POS_W-1:0];
                                end else if (i_req.data_byte == brle_pkg::ESC_EOL) begin
                                    n_s1_valid = 1'b1;
                                    n_s1_base  = fill_eol;
                                    n_col      = '0;
                                    n_line     = line_p1[brle_pkg::POS_W]
                                               ? brle_pkg::POS_MAX
                                               : line_p1[brle_pkg::POS_W-1:0];
                                end else if (i_req.data_byte == brle_pkg::ESC_EOB) begin
                                    n_s1_valid = 1'b1;
                                    n_s1_two   = 1'b1;
                                    n_s1_base  = fill_eol;
                                    n_s1_mul_a = lines_left;
                                    n_finished = 1'b1;
                                end else if (i_req.data_byte == brle_pkg::ESC_DELTA) begin
                                    n_phase = brle_pkg::PH_DX;
                                end else begin
                                    n_lit_rem     = i_req.data_byte;
                                    n_pad_pending = i_req.data_byte[0];
                                    n_phase       = brle_pkg::PH_LITERAL;
                                end
                            end
                            brle_pkg::PH_DX: begin
                                n_delta_dx = i_req.data_byte;
                                n_phase    = brle_pkg::PH_DY;
                            end
                            brle_pkg::PH_DY: begin
                                n_s1_valid   = 1'b1;
                                n_s1_mul_to0 = 1'b1;
                                n_s1_base    = brle_pkg::CFG_W'(r_delta_dx);
                                n_s1_mul_a   = brle_pkg::CFG_W'(i_req.data_byte);
                                n_col        = col_sum_b[brle_pkg::POS_W]
                                             ? brle_pkg::POS_MAX
                                             : col_sum_b[brle_pkg::POS_W-1:0];
                                n_line       = line_sum[brle_pkg::POS_W]
                                             ? brle_pkg::POS_MAX
                                             : line_sum[brle_pkg::POS_W-1:0];
                                n_phase      = brle_pkg::PH_COUNT;
                            end
                            brle_pkg::PH_LITERAL: begin
                                n_s1_valid = 1'b1;
                                n_s1_base  = brle_pkg::CFG_W'(1);
                                pal_raddr  = i_req.data_byte;
                                n_col      = (r_col == brle_pkg::POS_MAX) ? r_col : r_col + 1'b1;
                                n_lit_rem  = r_lit_rem - 1'b1;
                                if (r_lit_rem == brle_pkg::BYTE_W'(1)) begin
                                    n_phase = r_pad_pending ? brle_pkg::PH_PAD
                                                            : brle_pkg::PH_COUNT;
                                end
                            end
                            brle_pkg::PH_PAD: begin
                                n_pad_pending = 1'b0;
                                n_phase       = brle_pkg::PH_COUNT;
                            end
                            default: begin
                                n_phase = brle_pkg::PH_COUNT;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

    brle_ram #(
        .WIDTH(brle_pkg::COLOR_W),
        .DEPTH(brle_pkg::PALETTE_DEPTH)
    ) u_palette (
        .i_clk  (i_clk),
        .i_we   (pal_we),
        .i_waddr(i_req.data_byte),
        .i_wdata(pal_wdata),
        .i_re   (acc),
        .i_raddr(pal_raddr),
        .o_rdata(pal_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= brle_pkg::PH_COUNT;
            r_first_byte  <= '0;
            r_lit_rem     <= '0;
            r_pad_pending <= 1'b0;
            r_delta_dx    <= '0;
            r_col         <= '0;
            r_line        <= '0;
            r_finished    <= 1'b0;
            r_s1_valid    <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_first_byte  <= n_first_byte;
            r_lit_rem     <= n_lit_rem;
            r_pad_pending <= n_pad_pending;
            r_delta_dx    <= n_delta_dx;
            r_col         <= n_col;
            r_line        <= n_line;
            r_finished    <= n_finished;
            r_s1_valid    <= n_s1_valid;
        end
        r_s1_two     <= n_s1_two;
        r_s1_mul_to0 <= n_s1_mul_to0;
        r_s1_base    <= n_s1_base;
        r_s1_mul_a   <= n_s1_mul_a;
    end

    // Second stage: the palette color is on the RAM output; finish the counts.
    assign prod = PW'(r_s1_mul_a) * PW'(eff_w);
    assign sum0 = {1'b0, prod} + (PW+1)'(r_s1_base);
    assign cnt1 = (prod > PW'(brle_pkg::RUN_MAX)) ? brle_pkg::RUN_MAX
                                                  : brle_pkg::RUN_W'(prod);
    assign cnt0 = !r_s1_mul_to0 ? brle_pkg::RUN_W'(r_s1_base)
                : (sum0 > (PW+1)'(brle_pkg::RUN_MAX)) ? brle_pkg::RUN_MAX
                : brle_pkg::RUN_W'(sum0);

    assign push = r_s1_valid;
    assign head = r_q[r_rptr];

    assign o_res.valid        = (r_qcnt != '0);
    assign o_res.pixel_color  = head.color;
    assign o_res.repeat_count = r_sub ? head.cnt1 : head.cnt0;
    assign o_res.run_last     = !head.two || r_sub;
    assign o_res.image_done   = head.two && r_sub;

    assign pop = o_res.valid && o_res.ready && o_res.run_last;

    always_comb begin
        n_qcnt = r_qcnt;
        if (push && !pop) begin
            n_qcnt = r_qcnt + 1'b1;
        end else if (pop && !push) begin
            n_qcnt = r_qcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_qcnt <= '0;
            r_sub  <= 1'b0;
        end else begin
            r_qcnt <= n_qcnt;
            if (push) begin
                r_wptr <= (r_wptr == QAW'(brle_pkg::RESQ_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QAW'(brle_pkg::RESQ_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                r_sub  <= 1'b0;
            end else if (o_res.valid && o_res.ready) begin
                r_sub <= 1'b1;
            end
        end
        if (push) begin
            r_q[r_wptr] <= '{color: pal_rdata, cnt0: cnt0, cnt1: cnt1, two: r_s1_two};
        end
    end

    // The queue never holds more entries than it has room for.
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= QCW'(brle_pkg::RESQ_DEPTH))
        else $error("result queue count out of range");

    // A stage entry is only produced when the queue has a free slot for it.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_qcnt < QCW'(brle_pkg::RESQ_DEPTH) || pop))
        else $error("result queue overrun");

    // Image bytes after the end of the bitmap produce no runs.
    a_finished_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.cmd == brle_pkg::CMD_IMAGE && r_finished) |=> !r_s1_valid)
        else $error("run produced after end of bitmap");

    // The image-done run is always the last run of its request.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.image_done) |-> o_res.run_last)
        else $error("image_done without run_last");

endmodule
